FILE: src/cos_pkg.sv
// ----------------------------------------------------------------------------
// cos_pkg
// Shared types and constants of the cursor overlay save and restore block.
// ----------------------------------------------------------------------------
package cos_pkg;

  localparam int ADDR_W      = 48;
  localparam int PIX_W       = 32;
  localparam int COORD_W     = 13;
  localparam int PITCH_W     = 14;
  localparam int PROD_W      = COORD_W + PITCH_W;
  localparam int CELL_IDX_W  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd3;

  typedef enum logic {
    FUNC_DRAW  = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  frame_base;
    logic [PITCH_W-1:0] line_pitch;
    logic [COORD_W-1:0] screen_width;
    logic [COORD_W-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    func_e                 func;
    logic                  active;
    logic [CELL_IDX_W-1:0] idx;
    logic [COORD_W-1:0]    y;
    logic [ADDR_W-1:0]     base_x;
    logic [PIX_W-1:0]      colour;
    logic [PIX_W-1:0]      pixel;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic s1_valid;
    logic out_valid;
  } bk_status_t;

endpackage

FILE: src/cos_ram.sv
// ----------------------------------------------------------------------------
// cos_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cos_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/cos_front.sv
// ----------------------------------------------------------------------------
// cos_front
// Accepts cursor cell requests, clips them and works out cell index and the
// column part of the pixel address.
// ----------------------------------------------------------------------------
module cos_front import cos_pkg::*; #(
  parameter int CURSOR_SIZE = 16
) (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [3:0]  off_x_i,
  input  logic [3:0]  off_y_i,
  input  logic [15:0] mask_row_i,
  input  logic [31:0] draw_colour_i,
  input  logic [31:0] cur_pixel_i,
  input  cfg_t        cfg_i,
  input  q_status_t   q_status_i,
  output logic        push_o,
  output q_entry_t    entry_o
);

  localparam int Act = (CURSOR_SIZE < 16) ? CURSOR_SIZE : 16;

  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic               active;

  assign x = {1'b0, pos_x_i} + {9'b0, off_x_i};
  assign y = {1'b0, pos_y_i} + {9'b0, off_y_i};

  assign active = (int'(off_x_i) < CURSOR_SIZE) && (int'(off_y_i) < CURSOR_SIZE) &&
                  mask_row_i[4'd15 - off_x_i] &&
                  (x < cfg_i.screen_width) && (y < cfg_i.screen_height);

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    entry_o        = '0;
    entry_o.func   = func_e'(func_i);
    entry_o.active = active;
    entry_o.idx    = active ? CELL_IDX_W'(int'(off_y_i) * Act + int'(off_x_i)) : '0;
    entry_o.y      = y;
    entry_o.base_x = cfg_i.frame_base + {33'b0, x, 2'b00};
    entry_o.colour = draw_colour_i;
    entry_o.pixel  = cur_pixel_i;
  end

endmodule

FILE: src/cos_queue.sv
// ----------------------------------------------------------------------------
// cos_queue
// Short FIFO of classified cell requests between front and back.
// ----------------------------------------------------------------------------
module cos_queue import cos_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  entry_i,
  input  logic      pop_i,
  output q_entry_t  entry_o,
  output q_status_t status_o
);

  q_entry_t            store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + (QPTR_W + 1)'(1);
      2'b01:   count_d = count_q - (QPTR_W + 1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o        = store_q[rd_ptr_q];
  assign status_o.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

FILE: src/cos_back.sv
// ----------------------------------------------------------------------------
// cos_back
// Carries out draw and clear requests against the save store and builds the
// framebuffer write, with an output register towards the memory side.
// ----------------------------------------------------------------------------
module cos_back import cos_pkg::*; #(
  parameter int CURSOR_SIZE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  q_entry_t          entry_i,
  input  q_status_t         q_status_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              write_enable_o,
  output logic [ADDR_W-1:0] write_address_o,
  output logic [PIX_W-1:0]  write_data_o,
  output bk_status_t        status_o
);

  localparam int Act   = (CURSOR_SIZE < 16) ? CURSOR_SIZE : 16;
  localparam int Cells = Act * Act;
  localparam int IdxW  = $clog2(Cells);

  // issue stage
  logic              s1_ready;
  logic              ram_we;
  logic              ram_re;
  logic [IdxW-1:0]   cell_idx;
  logic [Cells-1:0]  cell_vld_q;
  logic [2*PIX_W-1:0] ram_rdata;

  // s1 stage
  logic              s1_valid_q;
  func_e             s1_func_q;
  logic              s1_active_q;
  logic              s1_vld_q;
  logic [ADDR_W-1:0] s1_base_x_q;
  logic [PROD_W-1:0] s1_prod_q;
  logic [PIX_W-1:0]  s1_colour_q;
  logic [PIX_W-1:0]  s1_pixel_q;

  // result
  logic              out_valid_q;
  logic              out_free;
  logic              s1_adv;
  logic [PIX_W-1:0]  drawn;
  logic [PIX_W-1:0]  saved;
  logic              res_we;
  logic [ADDR_W-1:0] res_addr;
  logic [PIX_W-1:0]  res_data;
  logic              we_q;
  logic [ADDR_W-1:0] addr_q;
  logic [PIX_W-1:0]  data_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_adv   = s1_valid_q && out_free;
  assign s1_ready = !s1_valid_q || out_free;
  assign pop_o    = !q_status_i.empty && s1_ready;

  assign cell_idx = entry_i.idx[IdxW-1:0];
  assign ram_we   = pop_o && entry_i.active && (entry_i.func == FUNC_DRAW);
  assign ram_re   = pop_o && entry_i.active && (entry_i.func == FUNC_CLEAR);

  cos_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (Cells)
  ) u_save_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cell_idx),
    .wdata_i ({entry_i.colour, entry_i.pixel}),
    .re_i    (ram_re),
    .raddr_i (cell_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        cell_vld_q[cell_idx] <= 1'b1;
      end
      if (s1_ready) begin
        s1_valid_q <= pop_o;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_func_q   <= entry_i.func;
      s1_active_q <= entry_i.active;
      s1_vld_q    <= entry_i.active && cell_vld_q[cell_idx];
      s1_base_x_q <= entry_i.base_x;
      s1_prod_q   <= {{PITCH_W{1'b0}}, entry_i.y} * {{COORD_W{1'b0}}, cfg_i.line_pitch};
      s1_colour_q <= entry_i.colour;
      s1_pixel_q  <= entry_i.pixel;
    end
    if (s1_adv) begin
      we_q   <= res_we;
      addr_q <= res_addr;
      data_q <= res_data;
    end
  end

  // cells never drawn since reset read as zero
  assign drawn = s1_vld_q ? ram_rdata[2*PIX_W-1:PIX_W] : '0;
  assign saved = s1_vld_q ? ram_rdata[PIX_W-1:0] : '0;

  always_comb begin
    res_we   = s1_active_q && ((s1_func_q == FUNC_DRAW) || (s1_pixel_q == drawn));
    res_addr = '0;
    res_data = '0;
    if (res_we) begin
      res_addr = s1_base_x_q + {{(ADDR_W - PROD_W - 2){1'b0}}, s1_prod_q, 2'b00};
      res_data = (s1_func_q == FUNC_DRAW) ? s1_colour_q : saved;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign write_enable_o    = we_q;
  assign write_address_o   = addr_q;
  assign write_data_o      = data_q;
  assign status_o.s1_valid  = s1_valid_q;
  assign status_o.out_valid = out_valid_q;

endmodule

FILE: src/cursor_overlay_save_restore.sv
// ----------------------------------------------------------------------------
// cursor_overlay_save_restore
// Software mouse cursor cell engine with save and restore of the pixels
// under the cursor; one framebuffer write request per cell request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_ready_o   func, pos, off, mask, colour, pixel
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//  out      source     out_valid_o / out_ready_i write_enable, address, data
//
//  one request per cycle sustained unless the output stalls; a result passes
//  the four-entry queue, save ram read and pitch multiply, output register
//  reset clears per-cell valid bits at once, no clearing pass
//  a stalled output holds the back, the queue lets the front run on until full
// ----------------------------------------------------------------------------
module cursor_overlay_save_restore import cos_pkg::*; #(
  parameter int CURSOR_SIZE = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [11:0]          pos_x_i,
  input  logic [11:0]          pos_y_i,
  input  logic [3:0]           off_x_i,
  input  logic [3:0]           off_y_i,
  input  logic [15:0]          mask_row_i,
  input  logic [31:0]          draw_colour_i,
  input  logic [31:0]          cur_pixel_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 write_enable_o,
  output logic [ADDR_W-1:0]    write_address_o,
  output logic [PIX_W-1:0]     write_data_o
);

  cfg_t       cfg_q;
  logic       push;
  logic       pop;
  q_entry_t   front_entry;
  q_entry_t   queue_entry;
  q_status_t  q_status;
  bk_status_t bk_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base    <= '0;
      cfg_q.line_pitch    <= PITCH_W'(1024);
      cfg_q.screen_width  <= COORD_W'(1024);
      cfg_q.screen_height <= COORD_W'(768);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_BASE:    cfg_q.frame_base    <= cfg_data_i;
        CFG_LINE_PITCH:    cfg_q.line_pitch    <= cfg_data_i[PITCH_W-1:0];
        CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[COORD_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  cos_front #(
    .CURSOR_SIZE (CURSOR_SIZE)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .off_x_i       (off_x_i),
    .off_y_i       (off_y_i),
    .mask_row_i    (mask_row_i),
    .draw_colour_i (draw_colour_i),
    .cur_pixel_i   (cur_pixel_i),
    .cfg_i         (cfg_q),
    .q_status_i    (q_status),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  cos_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .entry_o  (queue_entry),
    .status_o (q_status)
  );

  cos_back #(
    .CURSOR_SIZE (CURSOR_SIZE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .entry_i         (queue_entry),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_enable_o  (write_enable_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .status_o        (bk_status)
  );

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> (write_address_o == '0) && (write_data_o == '0))
    else $error("idle write carries address or data");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> !in_ready_o && !q_status.empty)
    else $error("full queue still takes requests");

  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_status.s1_valid))
    else $error("result appeared without a request in the back");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule
